[hdl/dert_pkg.sv]
// Shared types and constants for the short/long average ratio trigger.
`default_nettype none

package dert_pkg;

  // Item kinds on the input channel; the fourth code carries no meaning
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_MOTION = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_ALPHA_SHORT    = 3'd0;
  localparam logic [2:0] CFG_ALPHA_LONG     = 3'd1;
  localparam logic [2:0] CFG_RATIO          = 3'd2;
  localparam logic [2:0] CFG_REFRACTORY     = 3'd3;
  localparam logic [2:0] CFG_REQ_LONG_POS   = 3'd4;
  localparam logic [2:0] CFG_MOTION_GATE_EN = 3'd5;
  localparam logic [2:0] CFG_MOTION_FLOOR   = 3'd6;

  // Field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned RatioW = 16;
  localparam int unsigned RefrW  = 16;

  // Weight of one in Q1.16
  localparam logic [AlphaW-1:0] ALPHA_ONE = 17'd65536;

  // Register reset values
  localparam logic [AlphaW-1:0] ALPHA_SHORT_RST = 17'd6554;
  localparam logic [AlphaW-1:0] ALPHA_LONG_RST  = 17'd66;
  localparam logic [RatioW-1:0] RATIO_RST       = 16'd384;

endpackage

`default_nettype wire

[hdl/dual_ema_ratio_trigger_top.sv]
// Short/long exponential average ratio trigger, top level.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_ready  | kind, value, tick_number
//  out     | output    | out_valid / out_ready| event_tick, intensity
//  cfg     | input     | cfg_we (no stall)    | cfg_index, cfg_data
//
// One item per cycle while no firing tick is held: an item waits in the input
// register, where the two average updates (one 33x18 multiply each) or the
// ratio compare (one 32x17 multiply) settle, then state and the result register
// load together. A firing tick waits in the input register only while the
// result register is full and not being taken.
// Reset is synchronous, clears valid flags and block state, loads register defaults.
`default_nettype none

module dual_ema_ratio_trigger_top (
  input  wire logic                clk,
  input  wire logic                rst,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          kind,
  input  wire logic signed [31:0]  value,
  input  wire logic [31:0]         tick_number,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              event_tick,
  output logic signed [31:0]       intensity,
  // configuration write port
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  // Configuration registers
  logic [dert_pkg::AlphaW-1:0] wt_short;
  logic [dert_pkg::AlphaW-1:0] wt_long;
  logic [dert_pkg::RatioW-1:0] fire_ratio;
  logic [dert_pkg::RefrW-1:0]  holdoff_ticks;
  logic                        require_long_positive;
  logic                        motion_gate_enable;
  logic signed [31:0]          motion_floor;

  // Block state
  logic signed [31:0]          short_avg;
  logic signed [31:0]          long_avg;
  logic                        seeded;
  logic signed [31:0]          motion_value;
  logic                        motion_valid;
  logic [dert_pkg::RefrW-1:0]  refractory_left;

  // Input register
  logic                        q_valid;
  logic [1:0]                  q_kind;
  logic signed [31:0]          q_value;
  logic [31:0]                 q_tick;

  // Datapath
  logic [dert_pkg::AlphaW-1:0] a_short;
  logic [dert_pkg::AlphaW-1:0] a_long;
  logic signed [32:0]          diff_short;
  logic signed [32:0]          diff_long;
  logic signed [50:0]          prod_short;
  logic signed [50:0]          prod_long;
  logic signed [31:0]          short_upd;
  logic signed [31:0]          long_upd;
  logic signed [48:0]          lhs_scaled;
  logic signed [48:0]          rhs_scaled;
  logic [dert_pkg::RefrW-1:0]  refr_dec;
  logic                        is_sample;
  logic                        is_motion;
  logic                        is_tick;
  logic                        gate_ok;
  logic                        fire;
  logic                        out_free;
  logic                        advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wt_short              <= dert_pkg::ALPHA_SHORT_RST;
      wt_long               <= dert_pkg::ALPHA_LONG_RST;
      fire_ratio            <= dert_pkg::RATIO_RST;
      holdoff_ticks         <= '0;
      require_long_positive <= 1'b1;
      motion_gate_enable    <= 1'b0;
      motion_floor          <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dert_pkg::CFG_ALPHA_SHORT:    wt_short <= cfg_data[dert_pkg::AlphaW-1:0];
        dert_pkg::CFG_ALPHA_LONG:     wt_long <= cfg_data[dert_pkg::AlphaW-1:0];
        dert_pkg::CFG_RATIO:          fire_ratio <= cfg_data[dert_pkg::RatioW-1:0];
        dert_pkg::CFG_REFRACTORY:     holdoff_ticks <= cfg_data[dert_pkg::RefrW-1:0];
        dert_pkg::CFG_REQ_LONG_POS:   require_long_positive <= cfg_data[0];
        dert_pkg::CFG_MOTION_GATE_EN: motion_gate_enable <= cfg_data[0];
        dert_pkg::CFG_MOTION_FLOOR:   motion_floor <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Decode the held item
  assign is_sample = q_valid && (q_kind == dert_pkg::KIND_SAMPLE);
  assign is_motion = q_valid && (q_kind == dert_pkg::KIND_MOTION);
  assign is_tick   = q_valid && (q_kind == dert_pkg::KIND_TICK);

  // Clamp weights above one
  assign a_short = (wt_short > dert_pkg::ALPHA_ONE) ? dert_pkg::ALPHA_ONE : wt_short;
  assign a_long  = (wt_long > dert_pkg::ALPHA_ONE) ? dert_pkg::ALPHA_ONE : wt_long;

  // Average update: old + floor(a*(x-old) / 2^16)
  assign diff_short = {q_value[31], q_value} - {short_avg[31], short_avg};
  assign diff_long  = {q_value[31], q_value} - {long_avg[31], long_avg};
  assign prod_short = diff_short * signed'({1'b0, a_short});
  assign prod_long  = diff_long * signed'({1'b0, a_long});
  assign short_upd  = short_avg + prod_short[47:16];
  assign long_upd   = long_avg + prod_long[47:16];

  // Ratio compare: short*256 against long*ratio
  assign lhs_scaled = {{9{short_avg[31]}}, short_avg, 8'd0};
  assign rhs_scaled = long_avg * signed'({1'b0, fire_ratio});

  // Count the refractory time down before checking it
  assign refr_dec = (refractory_left != '0) ? refractory_left - 1'b1 : refractory_left;

  assign gate_ok = !motion_gate_enable ||
                   (motion_valid && (motion_value >= motion_floor));

  assign fire = is_tick && seeded &&
                (!require_long_positive || (long_avg > 32'sd0)) &&
                (refr_dec == '0) && gate_ok &&
                (lhs_scaled > rhs_scaled);

  // Hold a firing tick while the result register is full and not being taken
  assign out_free = !out_valid || out_ready;
  assign advance  = q_valid && (!fire || out_free);
  assign in_ready = !q_valid || advance;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_kind  <= kind;
      q_value <= value;
      q_tick  <= tick_number;
    end
  end

  // Advance block state
  always_ff @(posedge clk) begin
    if (rst) begin
      short_avg       <= '0;
      long_avg        <= '0;
      seeded          <= 1'b0;
      motion_value    <= '0;
      motion_valid    <= 1'b0;
      refractory_left <= '0;
    end else if (advance) begin
      if (is_sample) begin
        seeded    <= 1'b1;
        short_avg <= seeded ? short_upd : q_value;
        long_avg  <= seeded ? long_upd : q_value;
      end
      if (is_motion) begin
        motion_value <= q_value;
        motion_valid <= 1'b1;
      end
      if (is_tick) begin
        refractory_left <= fire ? holdoff_ticks : refr_dec;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      event_tick <= q_tick;
      intensity  <= short_avg;
    end
  end

  // Checks
  a_fire_needs_seed: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> seeded)
    else $error("result raised before the averages were seeded");

  a_seed_sticks: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded)
    else $error("seeded flag dropped without reset");

  a_refr_reload: assert property (@(posedge clk) disable iff (rst)
    (advance && fire) |=> (refractory_left == $past(holdoff_ticks)))
    else $error("refractory counter not reloaded on firing");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (q_valid && fire && out_valid && !out_ready))
    else $error("input stalled without a blocked firing tick");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the short/long average ratio trigger.
`timescale 1ns / 100ps

module tb_top;

  // The block has no name for the fourth kind code; it must be dropped
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned NUM_PHASES = 8;
  // Margin for the input and result registers to empty after the last event
  localparam int unsigned PIPE_CYCLES = 4;

  typedef struct {
    logic [dert_pkg::DataW-1:0]        tick_id;
    logic signed [dert_pkg::DataW-1:0] level;
  } fired_t;

  typedef struct {
    bit [dert_pkg::AlphaW-1:0]       alpha_s;
    bit [dert_pkg::AlphaW-1:0]       alpha_l;
    bit [dert_pkg::RatioW-1:0]       ratio;
    bit [dert_pkg::RefrW-1:0]        refr;
    bit                              need_pos;
    bit                              gate_en;
    bit signed [dert_pkg::DataW-1:0] floor_min;
  } setting_t;

  // Tracks the trigger state and the events it should fire
  class trigger_scoreboard;
    bit [dert_pkg::AlphaW-1:0]       wt_short;
    bit [dert_pkg::AlphaW-1:0]       wt_long;
    bit [dert_pkg::RatioW-1:0]       ratio;
    bit [dert_pkg::RefrW-1:0]        refr_ticks;
    bit                              need_long_pos;
    bit                              gate_on;
    bit signed [dert_pkg::DataW-1:0] floor_min;

    bit signed [dert_pkg::DataW-1:0] short_avg;
    bit signed [dert_pkg::DataW-1:0] long_avg;
    bit signed [dert_pkg::DataW-1:0] motion_level;
    bit                              seeded;
    bit                              motion_got;
    bit [dert_pkg::RefrW-1:0]        refr_left;

    fired_t      pending_events[$];
    int unsigned errors;
    int unsigned items;
    int unsigned fires;
    int unsigned checked;

    function new();
      wt_short      = dert_pkg::ALPHA_SHORT_RST;
      wt_long       = dert_pkg::ALPHA_LONG_RST;
      ratio         = dert_pkg::RATIO_RST;
      refr_ticks    = '0;
      need_long_pos = 1'b1;
      gate_on       = 1'b0;
      floor_min     = '0;
      short_avg     = '0;
      long_avg      = '0;
      motion_level  = '0;
      seeded        = 1'b0;
      motion_got    = 1'b0;
      refr_left     = '0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        dert_pkg::CFG_ALPHA_SHORT:    wt_short = data[dert_pkg::AlphaW-1:0];
        dert_pkg::CFG_ALPHA_LONG:     wt_long = data[dert_pkg::AlphaW-1:0];
        dert_pkg::CFG_RATIO:          ratio = data[dert_pkg::RatioW-1:0];
        dert_pkg::CFG_REFRACTORY:     refr_ticks = data[dert_pkg::RefrW-1:0];
        dert_pkg::CFG_REQ_LONG_POS:   need_long_pos = data[0];
        dert_pkg::CFG_MOTION_GATE_EN: gate_on = data[0];
        dert_pkg::CFG_MOTION_FLOOR:   floor_min = data;
        default: ;
      endcase
    endfunction

    // Weighted mean with Q1.16 weights; weights above one act as one
    function bit signed [dert_pkg::DataW-1:0] blend(bit signed [dert_pkg::DataW-1:0] prior,
                                                    bit signed [dert_pkg::DataW-1:0] x,
                                                    bit [dert_pkg::AlphaW-1:0] alpha);
      longint w;
      longint acc;
      w = (alpha > dert_pkg::ALPHA_ONE) ? longint'(dert_pkg::ALPHA_ONE) : longint'(alpha);
      acc = (longint'(dert_pkg::ALPHA_ONE) - w) * longint'(prior) + w * longint'(x);
      return 32'(acc >>> 16);
    endfunction

    // Advance the state by one accepted item and queue any event it fires
    function void note_item(logic [1:0] kind_code, logic signed [31:0] x,
                            logic [31:0] tick_id);
      fired_t ev;
      items++;
      case (kind_code)
        dert_pkg::KIND_SAMPLE: begin
          if (!seeded) begin
            short_avg = x;
            long_avg  = x;
            seeded    = 1'b1;
          end else begin
            short_avg = blend(short_avg, x, wt_short);
            long_avg  = blend(long_avg, x, wt_long);
          end
        end
        dert_pkg::KIND_MOTION: begin
          motion_level = x;
          motion_got   = 1'b1;
        end
        dert_pkg::KIND_TICK: begin
          if (refr_left != 0) refr_left--;
          if (seeded && !(need_long_pos && long_avg <= 0) && refr_left == 0 &&
              !(gate_on && (!motion_got || motion_level < floor_min)) &&
              longint'(short_avg) * 256 > longint'(long_avg) * longint'(ratio)) begin
            ev.tick_id = tick_id;
            ev.level   = short_avg;
            pending_events.insert(pending_events.size(), ev);
            refr_left = refr_ticks;
            fires++;
          end
        end
        default: ;
      endcase
    endfunction

    task check_event(logic [31:0] tick_id, logic signed [31:0] level);
      fired_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("event with none pending: tick %08h intensity %08h",
                         tick_id, level));
        return;
      end
      want = pending_events.pop_front();
      checked++;
      if (tick_id !== want.tick_id)
        report($sformatf("event_tick %08h, want %08h", tick_id, want.tick_id));
      if (level !== want.level)
        report($sformatf("intensity %08h, want %08h (tick %08h)",
                         level, want.level, want.tick_id));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          kind;
  logic signed [31:0]  value;
  logic [31:0]         tick_number;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [31:0]         event_tick;
  logic signed [31:0]  intensity;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [31:0]         cfg_data;

  trigger_scoreboard sb = new();
  int unsigned       send_idle_pct;
  int unsigned       stall_pct;
  int unsigned       cfg_writes;
  int unsigned       cycles = 0;
  logic signed [31:0] level;
  logic [31:0]       tick_seq;

  dual_ema_ratio_trigger_top u_top (.*);

  always #6 clk = ~clk;

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each accepted event
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_event(event_tick, intensity);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d events outstanding", cycles,
               sb.pending_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one item after a random gap; return at the falling edge after acceptance
  task automatic send_item(logic [1:0] k, logic signed [31:0] v, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    value       <= v;
    tick_number <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, v, t);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic apply_setting(setting_t s);
    cfg_write(dert_pkg::CFG_ALPHA_SHORT, 32'(s.alpha_s));
    cfg_write(dert_pkg::CFG_ALPHA_LONG, 32'(s.alpha_l));
    cfg_write(dert_pkg::CFG_RATIO, 32'(s.ratio));
    cfg_write(dert_pkg::CFG_REFRACTORY, 32'(s.refr));
    cfg_write(dert_pkg::CFG_REQ_LONG_POS, 32'(s.need_pos));
    cfg_write(dert_pkg::CFG_MOTION_GATE_EN, 32'(s.gate_en));
    cfg_write(dert_pkg::CFG_MOTION_FLOOR, s.floor_min);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every pending event, then let the pipeline empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  // Mostly sample/tick streams around a moving level, with motion values and noise
  task automatic run_phase(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [1:0] k;
    logic signed [31:0] v;
    logic [31:0] t;
    sent = 0;
    while (sent < count) begin
      // Step the level now and then, mostly upward so the short average leads
      if ($urandom_range(99) < 4) begin
        if (level > 0 && level < 32'sh1000_0000 && $urandom_range(3) != 0)
          level = level * 3;
        else begin
          level = int'($urandom_range(1 << 24)) + 1;
          if ($urandom_range(4) == 0) level = -level;
        end
      end
      pick = $urandom_range(99);
      k = dert_pkg::KIND_SAMPLE;
      v = level + int'($urandom_range(65535)) - 32768;
      t = ($urandom_range(99) < 15) ? $urandom : tick_seq;
      if (pick < 44) begin
        k = dert_pkg::KIND_SAMPLE;
      end else if (pick < 48) begin
        k = dert_pkg::KIND_SAMPLE;
        v = $urandom;
      end else if (pick < 80) begin
        k = dert_pkg::KIND_TICK;
        tick_seq++;
      end else if (pick < 92) begin
        k = dert_pkg::KIND_MOTION;
        case ($urandom_range(2))
          0: v = $urandom;
          1: v = sb.floor_min + int'($urandom_range(8)) - 4;
          default: v = level;
        endcase
      end else if (pick < 96) begin
        k = KIND_UNUSED;
        v = $urandom;
        t = $urandom;
      end else begin
        k = 2'($urandom_range(3));
        v = $urandom;
        t = $urandom;
      end
      send_item(k, v, t);
      if (k != KIND_UNUSED) sent++;
    end
  endtask

  initial begin
    setting_t s;
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = dert_pkg::KIND_SAMPLE;
    value         = '0;
    tick_number   = '0;
    cfg_we        = 1'b0;
    cfg_index     = dert_pkg::CFG_ALPHA_SHORT;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    cfg_writes    = 0;
    level         = 32'sh0010_0000;
    tick_seq      = 32'd100;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: tick before seeding, ignored kind, extreme values
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'h0000_0000);
    send_item(KIND_UNUSED, 32'sh7fff_ffff, 32'hffff_ffff);
    // motion stored while the gate is off, consulted later
    send_item(dert_pkg::KIND_MOTION, 32'sh8000_0000, 32'h0);
    send_item(dert_pkg::KIND_SAMPLE, 32'sh7fff_ffff, 32'h0);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'hffff_ffff);
    send_item(dert_pkg::KIND_SAMPLE, 32'sh8000_0000, 32'h0);
    send_item(dert_pkg::KIND_TICK, -32'sd1, 32'd1);
    send_item(dert_pkg::KIND_SAMPLE, 32'sd0, 32'h0);
    send_item(dert_pkg::KIND_SAMPLE, -32'sd1, 32'h0);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd2);
    drain_results();

    // Weight above one, frozen long average, zero ratio, short refractory
    s = '{17'h1ffff, 17'd0, 16'd0, 16'd2, 1'b0, 1'b1, 32'sh8000_0000};
    apply_setting(s);
    send_item(dert_pkg::KIND_SAMPLE, 32'sd1, 32'h0);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd3);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd4);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd5);
    send_item(dert_pkg::KIND_SAMPLE, -32'sd1, 32'h0);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd6);
    send_item(dert_pkg::KIND_MOTION, 32'sh7fff_ffff, 32'h0);
    send_item(dert_pkg::KIND_SAMPLE, 32'sh7fff_ffff, 32'h0);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd7);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd8);
    send_item(dert_pkg::KIND_TICK, 32'sd0, 32'd9);
    send_item(KIND_UNUSED, -32'sd1, 32'hffff_ffff);
    drain_results();

    // Random phases; the long refractory setting goes last so it cannot starve others
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: s = '{dert_pkg::ALPHA_SHORT_RST, dert_pkg::ALPHA_LONG_RST, dert_pkg::RATIO_RST,
                 16'd0, 1'b1, 1'b0, 32'sd0};
        1: s = '{dert_pkg::ALPHA_ONE, 17'd1, 16'd256, 16'd0, 1'b0, 1'b0, 32'sd0};
        2: s = '{17'd20000, 17'd300, 16'd320, 16'd3, 1'b1, 1'b1, -32'sd65536};
        4: s = '{17'h1ffff, 17'd65537, 16'd0, 16'd1, 1'b0, 1'b1, 32'sh8000_0000};
        7: s = '{17'd0, dert_pkg::ALPHA_ONE, 16'hffff, 16'hffff, 1'b1, 1'b1,
                 32'sh7fff_ffff};
        default: begin
          s.alpha_s   = 17'($urandom_range(131071));
          s.alpha_l   = 17'($urandom_range(6000));
          s.ratio     = 16'($urandom_range(900, 160));
          s.refr      = 16'($urandom_range(4));
          s.need_pos  = 1'($urandom_range(1));
          s.gate_en   = 1'($urandom_range(1));
          s.floor_min = int'($urandom_range(1 << 21)) - (1 << 20);
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      apply_setting(s);
      run_phase(PHASE_ITEMS);
      drain_results();
    end

    $display("Covered %0d items over %0d register writes and %0d settings,",
             sb.items, cfg_writes, NUM_PHASES + 2);
    $display("with %0d events predicted and %0d compared.", sb.fires, sb.checked);
    if (sb.pending_events.size() != 0)
      sb.report($sformatf("%0d expected events never arrived",
                          sb.pending_events.size()));
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
hdl/dert_pkg.sv
hdl/dual_ema_ratio_trigger_top.sv
verif/tb_top.sv
